// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;

  localparam int RoundCount = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_byte;   // shift in byte into block
    logic       start_blk;   // load working vars from hash words
    logic       round_en;    // run one round
    logic       finish_blk;  // add working vars into hash words
    logic       pad_open;    // shift in 0x80
    logic       pad_len;     // shift in next bit length byte
    logic       pad_zero;    // shift in a zero byte
    logic       restart;     // back to initial values
  } sha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       blk_full;    // next byte shifted in completes the block
    logic       len_fits;    // next byte lands before the length field
  } sha_stat_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// Channel | Ports                                            | Dir
// input   | in_valid, in_stall, in_data_byte, in_byte_present, in_message_end | in
// result  | out_valid, out_stall, out_digest_word, out_word_index, out_last_word | out
// While idle, one byte is taken per cycle; the byte that fills a block then runs a load,
// 64 rounds and an add on the single round unit, with in_stall high.
// Message end: one pad byte per cycle up to the end of the last block (one or
// two blocks), each padded block compressed, then 8 beats.
// rst_n is synchronous, active low; it restores the initial hash and zero count.
// While padding, compressing or emitting, in_stall is high; out_stall holds the word.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [5:0] round_idx;
  logic [2:0] word_sel;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_byte_present, .in_message_end, .in_stall,
    .out_valid, .out_stall, .stat, .cmd, .round_idx, .word_sel);

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_data_byte), .round_idx, .word_sel,
    .stat, .hash_word(out_digest_word));

  assign out_word_index = word_sel;
  assign out_last_word  = (word_sel == 3'd7);
endmodule

// ===== rtl/sha_datapath.sv =====
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]        in_byte,
  input  logic [5:0]        round_idx,
  input  logic [2:0]        word_sel,
  output sha_pkg::sha_stat_t stat,
  output logic [31:0]       hash_word
);
  import sha_pkg::*;

  logic [63:0]  bits_r, bits_nxt;
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];        // block bytes shift in here, then schedule window
  logic [5:0]   fill_r;          // bytes shifted into the current block
  logic         shift_en;
  logic [7:0]   shift_byte;
  logic [7:0]   len_byte;

  assign shift_en = cmd.load_byte | cmd.pad_open | cmd.pad_zero | cmd.pad_len;

  // big-endian length byte for block positions 56..63
  assign len_byte = 8'(bits_r >> {~fill_r[2:0], 3'b000});

  // byte entering the block
  always_comb begin
    priority if (cmd.load_byte) shift_byte = in_byte;
    else if (cmd.pad_open) shift_byte = PadByte;
    else if (cmd.pad_len) shift_byte = len_byte;
    else shift_byte = 8'h00;
  end

  // status
  always_comb begin
    stat.blk_full = (fill_r == 6'd63);
    stat.len_fits = (fill_r < LenPos);
  end

  assign hash_word = h_r[word_sel];

  // bit counter
  always_comb begin
    bits_nxt = bits_r;
    if (cmd.restart) bits_nxt = '0;
    else if (cmd.load_byte) bits_nxt = bits_r + 64'd8;
  end

  // schedule and round logic
  logic [31:0] wn, wcur, s0, s1, t1, t2, e, a;
  always_comb begin
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
    wcur = w_r[0];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v_r[5]) ^ (~e & v_r[6])) + RoundK[round_idx] + wcur;
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // hash words, bit count and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      fill_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
    end else begin
      bits_r <= bits_nxt;
      if (shift_en) fill_r <= fill_r + 6'd1;
      if (cmd.restart) begin
        for (int i = 0; i < 8; i++) h_r[i] <= InitH[i];
      end else if (cmd.finish_blk) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  // working vars
  always_ff @(posedge clk) begin
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  // byte shift while filling, word shift while compressing
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      w_r[15] <= {w_r[15][23:0], shift_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
    end
  end
endmodule

// ===== rtl/sha_ctrl.sv =====
`timescale 1ns / 1ps
module sha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_byte_present,
  input  logic               in_message_end,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sha_pkg::sha_stat_t stat,
  output sha_pkg::sha_cmd_t  cmd,
  output logic [5:0]         round_idx,
  output logic [2:0]         word_sel
);
  import sha_pkg::*;

  sha_state_t st_r, st_nxt;
  logic [6:0] cnt_r, cnt_nxt;      // 0 = load cycle, 1..64 rounds, 65 = add
  logic       end_r, end_nxt;      // message end pending
  logic       fin_r, fin_nxt;      // current block is the final one
  logic       open_r, open_nxt;    // 0x80 already shifted in
  logic       hold_r, hold_nxt;    // length goes into the next block
  logic [2:0] wi_r, wi_nxt;

  assign round_idx = cnt_r[5:0] - 6'd1;
  assign word_sel  = wi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; end_r <= 1'b0; fin_r <= 1'b0; wi_r <= '0;
      open_r <= 1'b0; hold_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; end_r <= end_nxt; fin_r <= fin_nxt; wi_r <= wi_nxt;
      open_r <= open_nxt; hold_r <= hold_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; end_nxt = end_r; fin_nxt = fin_r; wi_nxt = wi_r;
    open_nxt = open_r; hold_nxt = hold_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_byte = in_byte_present;
          end_nxt = in_message_end;
          fin_nxt = 1'b0;
          open_nxt = 1'b0;
          hold_nxt = 1'b0;
          cnt_nxt = '0;
          if (in_byte_present && stat.blk_full) st_nxt = ST_COMP;
          else if (in_message_end) st_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        // one pad byte per cycle: 0x80, zeros, then the length field
        if (!open_r) begin
          cmd.pad_open = 1'b1;
          open_nxt = 1'b1;
          hold_nxt = !stat.len_fits;
        end else if (hold_r || stat.len_fits) begin
          cmd.pad_zero = 1'b1;
        end else begin
          cmd.pad_len = 1'b1;
        end
        if (stat.blk_full) begin
          fin_nxt = open_r && !hold_r;
          hold_nxt = 1'b0;
          cnt_nxt = '0;
          st_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (cnt_r == 7'd0) cmd.start_blk = 1'b1;
        else cmd.round_en = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(RoundCount + 1)) begin
          cmd.round_en = 1'b0;
          cmd.finish_blk = 1'b1;
          cnt_nxt = '0;
          if (fin_r) begin
            st_nxt = ST_EMIT; wi_nxt = '0;
          end else if (end_r) st_nxt = ST_PAD;
          else st_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          wi_nxt = wi_r + 3'd1;
          if (wi_r == 3'd7) begin
            cmd.restart = 1'b1; end_nxt = 1'b0; st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== test/sha256_stream_hasher_test.sv =====
`timescale 1ns / 1ps
module sha256_stream_hasher_test;
  import sha_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } byte_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_message_end;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_byte_present(in_byte_present), .in_message_end(in_message_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word)
  );

  // Software copy of the hasher state
  logic [31:0] h_words [8];
  logic [7:0]  blk_bytes [64];
  logic [63:0] msg_bits;

  byte_beat_t   pending_bytes [$];
  digest_beat_t expected_digest [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int cycles;
  bit hold_sender;

  localparam int CycleLimit = 2000000;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) h_words[i] = InitH[i];
    msg_bits = '0;
  endtask

  task automatic compress_blk();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    int slot;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = h_words[i];
    for (int r = 0; r < 64; r++) begin
      slot = r & 15;
      if (r >= 16) begin
        s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
        s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
        w[slot] = s1 + w[(r-7)&15] + s0 + w[slot];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[slot];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_words[i] += v[i];
  endtask

  // Advance the software hasher by one accepted beat
  task automatic hash_beat(input byte_beat_t b);
    int pos;
    if (b.byte_present) begin
      pos = int'(msg_bits[8:3]);
      blk_bytes[pos] = b.data_byte;
      msg_bits += 64'd8;
      if (pos == 63) compress_blk();
    end
    if (b.message_end) begin
      pos = int'(msg_bits[8:3]);
      blk_bytes[pos] = PadByte;
      pos++;
      if (pos > 56) begin
        while (pos < 64) blk_bytes[pos++] = 8'h00;
        compress_blk();
        pos = 0;
      end
      while (pos < 56) blk_bytes[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
      compress_blk();
      for (int i = 0; i < 8; i++)
        expected_digest.push_back('{h_words[i], 3'(i), i == 7});
      restart_digest();
    end
  endtask

  task automatic add_message(input int len, input bit tail_byte);
    byte_beat_t b;
    for (int i = 0; i < len; i++) begin
      b.data_byte = 8'($urandom);
      b.byte_present = 1'b1;
      b.message_end = tail_byte && (i == len - 1);
      pending_bytes.push_back(b);
      // stray empty beats inside a message
      if ($urandom_range(0, 19) == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
    end
    if (!tail_byte || len == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_bytes.size() != 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid        <= 1'b1;
        in_data_byte    <= pending_bytes[0].data_byte;
        in_byte_present <= pending_bytes[0].byte_present;
        in_message_end  <= pending_bytes[0].message_end;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    digest_beat_t got;
    digest_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        hash_beat('{in_data_byte, in_byte_present, in_message_end});
      if (out_valid && !out_stall) begin
        got = '{out_digest_word, out_word_index, out_last_word};
        if (expected_digest.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest beat %h", got);
        end else begin
          want = expected_digest.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: exp word %h idx %0d last %0d, got %h %0d %0d",
                       want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
          end
        end
      end
    end
    out_stall <= rst_n ? ($urandom_range(0, 99) < recv_idle_pct) : 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_present = 1'b0;
    in_message_end = 1'b0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    cycles = 0;
    hold_sender = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 72;
    restart_digest();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, extreme bytes, empty beat, padding boundaries
    pending_bytes.push_back('{8'h00, 1'b0, 1'b1});
    pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
    pending_bytes.push_back('{8'h00, 1'b1, 1'b0});
    pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
    pending_bytes.push_back('{8'h55, 1'b1, 1'b0});
    pending_bytes.push_back('{8'haa, 1'b1, 1'b0});
    pending_bytes.push_back('{8'h00, 1'b0, 1'b1});
    add_message(55, 1'b1);
    add_message(56, 1'b0);
    add_message(64, 1'b1);

    // Wait out the directed part with the sender held
    wait (pending_bytes.size() == 0);
    hold_sender = 1'b1;
    wait (expected_digest.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    hold_sender = 1'b0;

    // Random messages, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 17 : 0;
      for (int m = 0; m < 3; m++)
        add_message(($urandom_range(0, 3) == 0) ? int'($urandom_range(56, 130))
                                                : int'($urandom_range(0, 12)),
                    1'($urandom_range(0, 1)));
      wait (pending_bytes.size() == 0);
    end

    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_digest.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
